// ----- sv/pidr_pkg.sv -----
// Shared types and constants for the PI duty regulator.
package pidr_pkg;

  localparam int GAIN_W     = 16;
  localparam int DUTY_W     = 16;
  localparam int LIMIT_W    = 12;
  localparam int INTEG_W    = 13;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_TARGET_LEVEL = 3'd0;
  localparam cfg_idx_t CFG_PROP_GAIN    = 3'd1;
  localparam cfg_idx_t CFG_INTEG_GAIN   = 3'd2;
  localparam cfg_idx_t CFG_INTEG_LIMIT  = 3'd3;
  localparam cfg_idx_t CFG_DUTY_BIAS    = 3'd4;
  localparam cfg_idx_t CFG_DUTY_FLOOR   = 3'd5;
  localparam cfg_idx_t CFG_DUTY_CEILING = 3'd6;

  localparam logic [GAIN_W-1:0]  RST_PROP_GAIN    = 16'd154;
  localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN   = 16'd38;
  localparam logic [LIMIT_W-1:0] RST_INTEG_LIMIT  = 12'd300;
  localparam logic [DUTY_W-1:0]  RST_DUTY_BIAS    = 16'd100;
  localparam logic [DUTY_W-1:0]  RST_DUTY_FLOOR   = 16'd10;
  localparam logic [DUTY_W-1:0]  RST_DUTY_CEILING = 16'd190;
  localparam int                 RST_TARGET_LEVEL = 410;

endpackage

// ----- sv/pi_duty_regulator.sv -----
// PI duty regulator: converter sample in, clamped PWM compare value out.
//
// Each accepted sample gives one result word through the input register,
// integral stage, multiply stage and output register, and a new sample is
// taken every cycle while the output is not stalled. The integral is updated
// from the input register, which lets samples follow each other back to back.
// The two gain multiplies run in parallel in their own stage; bias, clamping
// and truncation go in front of the output register. A stalled output holds
// the whole pipeline. Configuration is taken at any time on its own channel
// (cfg_ready is always high) and must only change while the block is idle.
module pi_duty_regulator
  import pidr_pkg::*;
#(
  parameter int SAMPLE_BITS    = 10,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [DUTY_W-1:0]      out_duty_compare,
  output logic                   out_integ_saturated,
  output logic                   out_duty_saturated,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  cfg_idx_t               cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int EW  = SAMPLE_BITS + 1;
  localparam int AW  = ((EW > INTEG_W) ? EW : INTEG_W) + 1;
  localparam int GW  = GAIN_W + 1;
  localparam int PW  = GW + EW;
  localparam int IW  = GW + INTEG_W;
  localparam int BW  = DUTY_W + GAIN_FRAC_BITS + 1;
  localparam int DW  = ((PW > BW) ? PW : BW) + 2;

  // configuration
  logic [SAMPLE_BITS-1:0] target_r;
  logic [GAIN_W-1:0]      prop_gain_r;
  logic [GAIN_W-1:0]      integ_gain_r;
  logic [LIMIT_W-1:0]     integ_limit_r;
  logic [DUTY_W-1:0]      duty_bias_r;
  logic [DUTY_W-1:0]      duty_floor_r;
  logic [DUTY_W-1:0]      duty_ceiling_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r       <= SAMPLE_BITS'(RST_TARGET_LEVEL);
      prop_gain_r    <= RST_PROP_GAIN;
      integ_gain_r   <= RST_INTEG_GAIN;
      integ_limit_r  <= RST_INTEG_LIMIT;
      duty_bias_r    <= RST_DUTY_BIAS;
      duty_floor_r   <= RST_DUTY_FLOOR;
      duty_ceiling_r <= RST_DUTY_CEILING;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TARGET_LEVEL: target_r       <= cfg_data[SAMPLE_BITS-1:0];
        CFG_PROP_GAIN:    prop_gain_r    <= cfg_data;
        CFG_INTEG_GAIN:   integ_gain_r   <= cfg_data;
        CFG_INTEG_LIMIT:  integ_limit_r  <= cfg_data[LIMIT_W-1:0];
        CFG_DUTY_BIAS:    duty_bias_r    <= cfg_data;
        CFG_DUTY_FLOOR:   duty_floor_r   <= cfg_data;
        CFG_DUTY_CEILING: duty_ceiling_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control: advance unless the output word is stalled
  logic advance;
  logic in_v_r, s1_v_r, s2_v_r, out_v_r;

  assign advance  = !out_v_r || out_ready;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (advance) begin
      in_v_r  <= in_valid;
      s1_v_r  <= in_v_r;
      s2_v_r  <= s1_v_r;
      out_v_r <= s2_v_r;
    end
  end

  // input register
  logic [SAMPLE_BITS-1:0] sample_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      sample_r <= in_sample;
    end
  end

  // integral stage
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [EW-1:0]      err;
  logic signed [AW-1:0]      acc;
  logic signed [AW-1:0]      lim_pos;
  logic signed [AW-1:0]      lim_neg;
  logic signed [AW-1:0]      acc_clamped;
  logic                      isat;

  assign err     = $signed({1'b0, sample_r}) - $signed({1'b0, target_r});
  assign acc     = AW'(integ_r) + AW'(err);
  assign lim_pos = $signed(AW'({1'b0, integ_limit_r}));
  assign lim_neg = -lim_pos;

  always_comb begin
    acc_clamped = acc;
    isat        = 1'b0;
    priority if (acc > lim_pos) begin
      acc_clamped = lim_pos;
      isat        = 1'b1;
    end else if (acc < lim_neg) begin
      acc_clamped = lim_neg;
      isat        = 1'b1;
    end else begin
      acc_clamped = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (advance && in_v_r) begin
      integ_r <= acc_clamped[INTEG_W-1:0];
    end
  end

  logic signed [EW-1:0]      s1_err_r;
  logic signed [INTEG_W-1:0] s1_acc_r;
  logic                      s1_isat_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_err_r  <= err;
      s1_acc_r  <= acc_clamped[INTEG_W-1:0];
      s1_isat_r <= isat;
    end
  end

  // multiply stage
  logic signed [PW-1:0] prop_prod;
  logic signed [IW-1:0] integ_prod;
  logic signed [PW-1:0] s2_prop_r;
  logic signed [IW-1:0] s2_integ_r;
  logic                 s2_isat_r;

  assign prop_prod  = PW'($signed({1'b0, prop_gain_r})) * PW'(s1_err_r);
  assign integ_prod = IW'($signed({1'b0, integ_gain_r})) * IW'(s1_acc_r);

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_prop_r  <= prop_prod;
      s2_integ_r <= integ_prod;
      s2_isat_r  <= s1_isat_r;
    end
  end

  // drive, clamp, truncate
  logic signed [DW-1:0] drive;
  logic signed [DW-1:0] drive_hi;
  logic signed [DW-1:0] drive_lo;
  logic signed [DW-1:0] drive_clamped;
  logic                 dsat;

  assign drive_hi = DW'($signed({1'b0, duty_ceiling_r})) <<< GAIN_FRAC_BITS;
  assign drive_lo = DW'($signed({1'b0, duty_floor_r})) <<< GAIN_FRAC_BITS;
  assign drive    = (DW'($signed({1'b0, duty_bias_r})) <<< GAIN_FRAC_BITS)
                  - (DW'(s2_prop_r) + DW'(s2_integ_r));

  always_comb begin
    drive_clamped = drive;
    dsat          = 1'b0;
    priority if (drive > drive_hi) begin
      drive_clamped = drive_hi;
      dsat          = 1'b1;
    end else if (drive < drive_lo) begin
      drive_clamped = drive_lo;
      dsat          = 1'b1;
    end else begin
      drive_clamped = drive;
    end
  end

  logic [DUTY_W-1:0] duty_r;
  logic              isat_r;
  logic              dsat_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      duty_r <= drive_clamped[GAIN_FRAC_BITS +: DUTY_W];
      isat_r <= s2_isat_r;
      dsat_r <= dsat;
    end
  end

  assign out_valid           = out_v_r;
  assign out_duty_compare    = duty_r;
  assign out_integ_saturated = isat_r;
  assign out_duty_saturated  = dsat_r;

  // checks
  a_integ_tracks_s1: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (s1_acc_r == integ_r))
    else $error("integral register out of step with integral stage");

  a_integ_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> (integ_r == '0))
    else $error("integral not cleared by reset");

  a_duty_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !dsat_r) |-> ((duty_r >= duty_floor_r) && (duty_r <= duty_ceiling_r)))
    else $error("unsaturated duty outside floor and ceiling");

endmodule

// ----- test/pidr_checker.sv -----
`timescale 1ns / 1ps
// Watches the PI duty regulator's channels, predicts every duty word and compares it.
module pidr_checker
  import pidr_pkg::*;
#(
  parameter int SAMPLE_BITS    = 10,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [DUTY_W-1:0]      out_duty_compare,
  input  logic                   out_integ_saturated,
  input  logic                   out_duty_saturated,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  cfg_idx_t               cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     words_owed
);

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              isat;
    logic              dsat;
  } duty_word_t;

  int target_level;
  int prop_gain;
  int integ_gain;
  int integ_limit;
  int duty_bias;
  int duty_floor;
  int duty_ceiling;
  int integral;

  duty_word_t duty_forecast[$];

  function automatic duty_word_t regulate(input logic [SAMPLE_BITS-1:0] sample);
    duty_word_t w;
    int         err;
    int         acc;
    longint     drive;
    longint     hi;
    longint     lo;
    err    = int'(sample) - target_level;
    acc    = integral + err;
    w.isat = 1'b0;
    w.dsat = 1'b0;
    if (acc > integ_limit) begin
      acc    = integ_limit;
      w.isat = 1'b1;
    end else if (acc < -integ_limit) begin
      acc    = -integ_limit;
      w.isat = 1'b1;
    end
    integral = acc;
    hi    = longint'(duty_ceiling) <<< GAIN_FRAC_BITS;
    lo    = longint'(duty_floor) <<< GAIN_FRAC_BITS;
    drive = (longint'(duty_bias) <<< GAIN_FRAC_BITS)
          - (longint'(prop_gain) * err + longint'(integ_gain) * acc);
    if (drive > hi) begin
      drive  = hi;
      w.dsat = 1'b1;
    end else if (drive < lo) begin
      drive  = lo;
      w.dsat = 1'b1;
    end
    w.duty = DUTY_W'(drive >>> GAIN_FRAC_BITS);
    return w;
  endfunction

  always @(posedge clk) begin
    duty_word_t want;
    if (!rst_n) begin
      target_level = RST_TARGET_LEVEL;
      prop_gain    = int'(RST_PROP_GAIN);
      integ_gain   = int'(RST_INTEG_GAIN);
      integ_limit  = int'(RST_INTEG_LIMIT);
      duty_bias    = int'(RST_DUTY_BIAS);
      duty_floor   = int'(RST_DUTY_FLOOR);
      duty_ceiling = int'(RST_DUTY_CEILING);
      integral     = 0;
      fail_count   = 0;
      duty_forecast.delete();
      words_owed <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TARGET_LEVEL: target_level = int'(cfg_data[SAMPLE_BITS-1:0]);
          CFG_PROP_GAIN:    prop_gain    = int'(cfg_data);
          CFG_INTEG_GAIN:   integ_gain   = int'(cfg_data);
          CFG_INTEG_LIMIT:  integ_limit  = int'(cfg_data[LIMIT_W-1:0]);
          CFG_DUTY_BIAS:    duty_bias    = int'(cfg_data);
          CFG_DUTY_FLOOR:   duty_floor   = int'(cfg_data);
          CFG_DUTY_CEILING: duty_ceiling = int'(cfg_data);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (duty_forecast.size() == 0) begin
          if (fail_count < 10) begin
            $display("%0t: unexpected word duty=%0d isat=%0b dsat=%0b", $realtime,
                     out_duty_compare, out_integ_saturated, out_duty_saturated);
          end
          fail_count++;
        end else begin
          want = duty_forecast.pop_front();
          if (out_duty_compare !== want.duty || out_integ_saturated !== want.isat ||
              out_duty_saturated !== want.dsat) begin
            if (fail_count < 10) begin
              $display("%0t: word mismatch: expected duty=%0d isat=%0b dsat=%0b, got duty=%0d isat=%0b dsat=%0b",
                       $realtime, want.duty, want.isat, want.dsat,
                       out_duty_compare, out_integ_saturated, out_duty_saturated);
            end
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        duty_forecast.push_back(regulate(in_sample));
      end
      words_owed <= duty_forecast.size();
    end
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Top of the PI duty regulator testbench: clock, reset, stimulus and verdict.
module testbench;
  import pidr_pkg::*;

  localparam int       SAMPLE_BITS    = 10;
  localparam int       GAIN_FRAC_BITS = 8;
  localparam int       RANDOM_PHASES  = 9;
  localparam int       PHASE_WORDS    = 150;
  localparam int       RX_HOLD_CYCLES = 250;
  localparam int       CYCLE_LIMIT    = 200000;
  localparam cfg_idx_t CFG_SPARE      = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   out_valid;
  logic                   out_ready;
  logic [DUTY_W-1:0]      out_duty_compare;
  logic                   out_integ_saturated;
  logic                   out_duty_saturated;
  logic                   cfg_valid;
  logic                   cfg_ready;
  cfg_idx_t               cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int fail_count;
  int words_owed;
  int cycles = 0;
  int target_now;
  bit burst;
  bit rx_hold;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pi_duty_regulator #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_sample           (in_sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_duty_compare    (out_duty_compare),
    .out_integ_saturated (out_integ_saturated),
    .out_duty_saturated  (out_duty_saturated),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  pidr_checker #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_sample           (in_sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_duty_compare    (out_duty_compare),
    .out_integ_saturated (out_integ_saturated),
    .out_duty_saturated  (out_duty_saturated),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .fail_count          (fail_count),
    .words_owed          (words_owed)
  );

  function automatic logic [CFG_DATA_W-1:0] rail();
    return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_regs(input logic [15:0] tgt, input logic [15:0] kp,
                           input logic [15:0] ki, input logic [15:0] lim,
                           input logic [15:0] bias, input logic [15:0] dfloor,
                           input logic [15:0] dceil);
    write_reg(CFG_TARGET_LEVEL, tgt);
    write_reg(CFG_PROP_GAIN, kp);
    write_reg(CFG_INTEG_GAIN, ki);
    write_reg(CFG_INTEG_LIMIT, lim);
    write_reg(CFG_DUTY_BIAS, bias);
    write_reg(CFG_DUTY_FLOOR, dfloor);
    write_reg(CFG_DUTY_CEILING, dceil);
    write_reg(CFG_SPARE, 16'($urandom));
    cfg_valid  <= 1'b0;
    target_now = int'(tgt[SAMPLE_BITS-1:0]);
  endtask

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] sample);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= sample;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_owed != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int gap;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
      gap = burst ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL pi_duty_regulator");
      $finish;
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_sample  <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_TARGET_LEVEL;
    cfg_data   <= '0;
    burst      = 1'b0;
    rx_hold    = 1'b0;
    target_now = RST_TARGET_LEVEL;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset gains: integral lands on each limit exactly, then runs past it
    send_sample(10'd710);
    send_sample(10'd410);
    send_sample(10'd1023);
    send_sample(10'd110);
    send_sample(10'd110);
    send_sample(10'd0);
    send_sample(10'd410);
    drain();

    // zero limit, drive on and just past floor and ceiling
    load_regs(16'd500, 16'd256, 16'd0, 16'd0, 16'd100, 16'd10, 16'd190);
    send_sample(10'd410);
    send_sample(10'd409);
    send_sample(10'd590);
    send_sample(10'd591);
    send_sample(10'd500);
    drain();

    // floor above ceiling
    load_regs(16'd500, 16'd256, 16'd0, 16'hFFFF, 16'd100, 16'd200, 16'd50);
    send_sample(10'd400);
    send_sample(10'd500);
    send_sample(10'd700);
    send_sample(10'd1023);
    drain();

    // widest registers
    load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
    repeat (5) send_sample('0);
    repeat (2) send_sample('1);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      int lo;
      int r;
      int s;
      case (p % 3)
        0: begin
          lo = $urandom_range(0, 200);
          load_regs(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1024)),
                    16'($urandom_range(0, 512)), 16'($urandom_range(0, 600)),
                    16'($urandom_range(0, 1000)), 16'(lo),
                    16'(lo + $urandom_range(0, 800)));
        end
        1: begin
          load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom));
        end
        default: begin
          load_regs(rail(), rail(), rail(), rail(), rail(), rail(), rail());
        end
      endcase
      if (p == 2) begin
        rx_hold = 1'b1;
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n % 40 == 0) begin
          burst = ($urandom_range(0, 3) == 0);
        end
        if (p == 4 && n == PHASE_WORDS / 2) begin
          drain();
        end
        r = $urandom_range(0, 9);
        if (r < 6) begin
          s = target_now + int'($urandom_range(0, 64)) - 32;
          if (s < 0) s = 0;
          if (s > 1023) s = 1023;
        end else if (r < 8) begin
          s = $urandom_range(0, 1023);
        end else begin
          s = (r == 8) ? 0 : 1023;
        end
        send_sample(SAMPLE_BITS'(s));
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("PASS pi_duty_regulator");
    end else begin
      $display("FAIL pi_duty_regulator");
    end
    $finish;
  end

endmodule
